### src/lmc_pkg.sv
// lightmap texel combine/pack: shared types and constants
// used by the channel interfaces and by the core; no dependencies
`timescale 1ns / 1ps

package lmc_pkg;

  localparam int MAX_STYLES      = 4;
  localparam int SCALE_FRAC_BITS = 8;
  localparam int GAMMA_DEPTH     = 256;

  localparam int NUM_CH    = 3;
  localparam int CHAN_W    = 8;
  localparam int SCALE_W   = 10;
  localparam int ACC_W     = 20;
  localparam int LVL_W     = ACC_W - SCALE_FRAC_BITS;
  localparam int CNT_W     = $clog2(MAX_STYLES + 1);
  localparam int GAMMA_AW  = $clog2(GAMMA_DEPTH);
  localparam int SAT_W     = 9;
  localparam int CFG_W     = SAT_W;
  localparam int CFG_AW    = 2;
  localparam int PROD_W    = 2 * SCALE_W;
  localparam int SUM_W     = CHAN_W + 2;
  localparam int WIDE_W    = 2 * CHAN_W;
  localparam int DIV_STEPS = CHAN_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // floor(x / 3) = (x * 683) >> 11 for every x up to 767
  localparam int THIRD_SHIFT = 11;

  localparam logic [SAT_W-1:0]   SAT_LOW   = 9'd77;
  localparam logic [SAT_W-1:0]   SAT_HIGH  = 9'd256;
  localparam logic [SAT_W-1:0]   SAT_RESET = 9'd256;
  localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;
  localparam logic [CHAN_W-1:0]  CAP_FULL  = 8'd255;
  localparam logic [CHAN_W-1:0]  CAP_HALF  = 8'd128;
  localparam logic [SCALE_W-1:0] THIRD_MUL = 10'd683;
  localparam logic [WIDE_W-1:0]  LUMA_RB   = 16'd84;
  localparam logic [WIDE_W-1:0]  LUMA_G    = 16'd87;
  localparam logic [SCALE_W-1:0] CEIL3_ADD = 10'd2;
  localparam logic [1:0]         CH_LAST   = 2'd2;

  typedef enum logic [0:0] {
    OP_SAMPLE,
    OP_GAMMA_LOAD
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_LUMA,
    MODE_FAKED,
    MODE_INVERSE
  } mode_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_SATURATION,
    REG_HALF_RANGE,
    REG_MONO_MODE,
    REG_TRANSLUCENT
  } reg_index_t;

  // what a finished division is for
  typedef enum logic [1:0] {
    JOB_OVER,
    JOB_FC_SUM,
    JOB_FC_CHAN
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC_MUL,
    S_MAC_ADD,
    S_LOOK_RD,
    S_LOOK_WR,
    S_OVER,
    S_OB_MUL,
    S_DIV_LD,
    S_DIV,
    S_DIV_WR,
    S_MODE,
    S_BL_MUL1,
    S_BL_MUL2,
    S_BL_WR,
    S_FC_MUL,
    S_OUT
  } state_t;

endpackage

### src/lmc_ifs.sv
// valid/ready channel interfaces for style samples in and packed texels out
// depends on lmc_pkg for field widths
`timescale 1ns / 1ps

interface lmc_in_if import lmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [0:0]         opcode;
  logic [CHAN_W-1:0]  sample_red;
  logic [CHAN_W-1:0]  sample_green;
  logic [CHAN_W-1:0]  sample_blue;
  logic [SCALE_W-1:0] scale_red;
  logic [SCALE_W-1:0] scale_green;
  logic [SCALE_W-1:0] scale_blue;
  logic               last_map;
  logic [GAMMA_AW-1:0] table_index;
  logic [CHAN_W-1:0]  table_value;

  modport source (
    output valid, opcode, sample_red, sample_green, sample_blue,
           scale_red, scale_green, scale_blue, last_map, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, sample_red, sample_green, sample_blue,
           scale_red, scale_green, scale_blue, last_map, table_index, table_value,
    output ready
  );
endinterface

interface lmc_out_if import lmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

### src/lightmap_texel_combine_pack_core.sv
// Lightmap texel combiner and packer. Each style sample is accepted in the idle state;
// then, per channel, the single shared multiplier scales the red, green or blue byte
// and the accumulator adds the product with saturation. A gamma table load is written
// as it is accepted, and the block stays idle. On the last style (or after MAX_STYLES
// styles) the texel is finished by the same sequencer: gamma table reads (one read
// port, one channel at a time), an overbright check, and if the texel is overbright a
// multiply and 8-step restoring divide per channel; then the pack for normal colour,
// luminance, inverse alpha or faked colour (for faked colour a reciprocal multiply for
// the divide by three, then per channel a multiply and a shift-add divide by 255); and
// a final state that loads the output register, held while it still holds an unread
// texel. The output register holds a finished texel while the next samples are taken;
// the block is not ready while it works on a sample. Depends on lmc_pkg and lmc_ifs.
`timescale 1ns / 1ps

module lightmap_texel_combine_pack_core import lmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CFG_AW-1:0] wr_index,
  input  logic [CFG_W-1:0]  wr_data,
  lmc_in_if.sink            samples,
  lmc_out_if.source         texels
);

  state_t state, state_next;
  job_t   job;

  // configuration
  logic [SAT_W-1:0] saturation;
  logic             half_range;
  mode_t            mono_mode;
  logic             translucent;

  // texel state
  logic [ACC_W-1:0]   acc [NUM_CH];
  logic [CNT_W-1:0]   count;
  logic [CNT_W:0]     cnt_inc;
  logic               fin;
  logic [1:0]         ch;
  logic [CHAN_W-1:0]  smp [NUM_CH];
  logic [SCALE_W-1:0] scl [NUM_CH];
  logic [CHAN_W-1:0]  c [NUM_CH];
  logic [CHAN_W-1:0]  a;

  // shared multiplier and divider
  logic [SCALE_W-1:0] mul_x, mul_y;
  logic [PROD_W-1:0]  mul_p, prod;
  logic [WIDE_W-1:0]  tmp;
  logic [CHAN_W-1:0]  den, div_rem, div_low;
  logic [DCNT_W-1:0]  dcnt;
  logic [CHAN_W:0]    div_t;
  logic               div_ge;
  logic [WIDE_W-1:0]  fc_sum;

  // gamma table
  logic [CHAN_W-1:0] gamma [GAMMA_DEPTH];
  logic [CHAN_W-1:0] gq;

  // output register
  logic              out_full, out_free;
  logic [CHAN_W-1:0] o_red, o_green, o_blue, o_alpha;

  // combinational helpers
  logic [LVL_W-1:0]  lvl_w [NUM_CH];
  logic [LVL_W-1:0]  lvl_v [NUM_CH];
  logic [LVL_W-1:0]  lvl_l [NUM_CH];
  logic [CHAN_W-1:0] lev [NUM_CH];
  logic              lit;
  logic [ACC_W:0]    acc_sum;
  logic [CHAN_W-1:0] cap, mx_c, mx_rg;
  logic [SUM_W-1:0]  sum_c, cap3;
  logic              over;
  logic [SAT_W-1:0]  sat_eff, sat_inv;
  logic [WIDE_W-1:0] luma_sum;
  logic [WIDE_W:0]   bl_sum;
  logic              in_fire;

  assign samples.ready = (state == S_IDLE);
  assign in_fire       = samples.valid && samples.ready;
  assign out_free      = !out_full || texels.ready;

  assign texels.valid     = out_full;
  assign texels.out_red   = o_red;
  assign texels.out_green = o_green;
  assign texels.out_blue  = o_blue;
  assign texels.out_alpha = o_alpha;

  assign cnt_inc = {1'b0, count} + 1'b1;

  // accumulator to channel level: drop fraction, minus one, floor, lit bump, cap
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      lvl_w[i] = acc[i][ACC_W-1:SCALE_FRAC_BITS];
      lvl_v[i] = (lvl_w[i] == '0) ? '0 : lvl_w[i] - 1'b1;
    end
    lit = (lvl_v[0] != '0) || (lvl_v[1] != '0) || (lvl_v[2] != '0);
    for (int i = 0; i < NUM_CH; i++) begin
      lvl_l[i] = lvl_v[i] + LVL_W'(lit);
      lev[i]   = (lvl_l[i] > LVL_W'(CHAN_MAX)) ? CHAN_MAX : lvl_l[i][CHAN_W-1:0];
    end
  end

  assign acc_sum = {1'b0, acc[ch]} + (ACC_W + 1)'(prod);

  assign cap   = half_range ? CAP_HALF : CAP_FULL;
  assign cap3  = (SUM_W'(cap) << 1) + SUM_W'(cap);
  assign sum_c = SUM_W'(c[0]) + SUM_W'(c[1]) + SUM_W'(c[2]);
  assign over  = sum_c > cap3;
  assign mx_rg = (c[0] > c[1]) ? c[0] : c[1];
  assign mx_c  = (c[2] > mx_rg) ? c[2] : mx_rg;

  always_comb begin
    if (saturation < SAT_LOW) begin
      sat_eff = SAT_LOW;
    end else if (saturation > SAT_HIGH) begin
      sat_eff = SAT_HIGH;
    end else begin
      sat_eff = saturation;
    end
  end
  assign sat_inv = SAT_HIGH - sat_eff;

  assign luma_sum = LUMA_RB * (WIDE_W'(c[0]) + WIDE_W'(c[2])) + LUMA_G * WIDE_W'(c[1]);
  assign bl_sum   = (WIDE_W + 1)'(tmp) + (WIDE_W + 1)'(prod[WIDE_W-1:0]);

  // floor(x / 255) = (x + (x >> 8) + 1) >> 8 for products of two bytes
  assign fc_sum = prod[WIDE_W-1:0] + WIDE_W'(prod[WIDE_W-1:CHAN_W]) + WIDE_W'(1);

  // shared multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      S_MAC_MUL: begin
        mul_x = scl[ch];
        mul_y = SCALE_W'(smp[ch]);
      end
      S_OB_MUL: begin
        mul_x = SCALE_W'(c[ch]);
        mul_y = SCALE_W'(cap);
      end
      S_MODE: begin
        mul_x = SCALE_W'(sum_c) + CEIL3_ADD;
        mul_y = THIRD_MUL;
      end
      S_BL_MUL1: begin
        mul_x = SCALE_W'(c[ch]);
        mul_y = SCALE_W'(sat_eff);
      end
      S_BL_MUL2: begin
        mul_x = SCALE_W'(a);
        mul_y = SCALE_W'(sat_inv);
      end
      S_FC_MUL: begin
        mul_x = SCALE_W'(c[ch]);
        mul_y = SCALE_W'(a);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // one restoring divide step; remainder stays below the divisor
  assign div_t  = {div_rem, div_low[CHAN_W-1]};
  assign div_ge = div_t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && samples.opcode == OP_SAMPLE) state_next = S_MAC_MUL;
      end
      S_MAC_MUL: state_next = S_MAC_ADD;
      S_MAC_ADD: begin
        if (ch == CH_LAST) state_next = fin ? S_LOOK_RD : S_IDLE;
        else state_next = S_MAC_MUL;
      end
      S_LOOK_RD: state_next = S_LOOK_WR;
      S_LOOK_WR: state_next = (ch == CH_LAST) ? S_OVER : S_LOOK_RD;
      S_OVER:    state_next = over ? S_OB_MUL : S_MODE;
      S_OB_MUL:  state_next = S_DIV_LD;
      S_DIV_LD:  state_next = S_DIV;
      S_DIV: begin
        if (dcnt == DCNT_W'(DIV_STEPS - 1)) state_next = S_DIV_WR;
      end
      S_DIV_WR: begin
        unique case (job)
          JOB_OVER:    state_next = (ch == CH_LAST) ? S_MODE : S_OB_MUL;
          JOB_FC_SUM:  state_next = S_FC_MUL;
          JOB_FC_CHAN: state_next = (ch == CH_LAST) ? S_OUT : S_FC_MUL;
          default: ;
        endcase
      end
      S_MODE: begin
        unique case (mono_mode)
          MODE_NORMAL:             state_next = S_BL_MUL1;
          MODE_FAKED:              state_next = S_DIV_WR;
          MODE_LUMA, MODE_INVERSE: state_next = S_OUT;
        endcase
      end
      S_BL_MUL1: state_next = S_BL_MUL2;
      S_BL_MUL2: state_next = S_BL_WR;
      S_BL_WR:   state_next = (ch == CH_LAST) ? S_OUT : S_BL_MUL1;
      S_FC_MUL:  state_next = S_DIV_WR;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
    endcase
  end

  // gamma table: written on a load transaction, read one channel per visit
  always_ff @(posedge clk) begin
    if (in_fire && samples.opcode == OP_GAMMA_LOAD) begin
      gamma[samples.table_index] <= samples.table_value;
    end
    if (state == S_LOOK_RD) begin
      gq <= gamma[lev[ch]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation  <= SAT_RESET;
      half_range  <= 1'b0;
      mono_mode   <= MODE_NORMAL;
      translucent <= 1'b0;
      count       <= '0;
      ch          <= '0;
      out_full    <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) acc[i] <= '0;
    end else begin
      if (wr_en) begin
        unique case (reg_index_t'(wr_index))
          REG_SATURATION:  saturation  <= wr_data;
          REG_HALF_RANGE:  half_range  <= wr_data[0];
          REG_MONO_MODE:   mono_mode   <= mode_t'(wr_data[1:0]);
          REG_TRANSLUCENT: translucent <= wr_data[0];
        endcase
      end

      // a reload in S_OUT sets the flag below
      if (texels.valid && texels.ready && state != S_OUT) out_full <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_fire && samples.opcode == OP_SAMPLE) begin
            smp[0] <= samples.sample_red;
            smp[1] <= samples.sample_green;
            smp[2] <= samples.sample_blue;
            scl[0] <= samples.scale_red;
            scl[1] <= samples.scale_green;
            scl[2] <= samples.scale_blue;
            ch     <= '0;
            if (samples.last_map || cnt_inc >= (CNT_W + 1)'(MAX_STYLES)) begin
              fin   <= 1'b1;
              count <= '0;
            end else begin
              fin   <= 1'b0;
              count <= cnt_inc[CNT_W-1:0];
            end
          end
        end
        S_MAC_MUL: prod <= mul_p;
        S_MAC_ADD: begin
          acc[ch] <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          ch      <= (ch == CH_LAST) ? '0 : ch + 2'd1;
        end
        S_LOOK_WR: begin
          c[ch] <= gq;
          if (ch == CH_LAST) begin
            ch <= '0;
            for (int i = 0; i < NUM_CH; i++) acc[i] <= '0;
          end else begin
            ch <= ch + 2'd1;
          end
        end
        S_OVER: begin
          den <= mx_c;
          job <= JOB_OVER;
        end
        S_OB_MUL: prod <= mul_p;
        S_DIV_LD: begin
          div_rem <= prod[WIDE_W-1:CHAN_W];
          div_low <= prod[CHAN_W-1:0];
          dcnt    <= '0;
        end
        S_DIV: begin
          div_rem <= div_ge ? CHAN_W'(div_t - {1'b0, den}) : div_t[CHAN_W-1:0];
          div_low <= {div_low[CHAN_W-2:0], div_ge};
          dcnt    <= dcnt + 1'b1;
        end
        S_DIV_WR: begin
          unique case (job)
            JOB_OVER: begin
              c[ch] <= div_low;
              ch    <= (ch == CH_LAST) ? '0 : ch + 2'd1;
            end
            JOB_FC_CHAN: begin
              c[ch] <= fc_sum[WIDE_W-1:CHAN_W];
              ch    <= (ch == CH_LAST) ? '0 : ch + 2'd1;
            end
            JOB_FC_SUM: begin
              a  <= CHAN_MAX - prod[THIRD_SHIFT+CHAN_W-1:THIRD_SHIFT];
              ch <= '0;
            end
            default: ;
          endcase
        end
        S_MODE: begin
          unique case (mono_mode)
            MODE_NORMAL: a <= luma_sum[WIDE_W-1:CHAN_W];
            MODE_LUMA: begin
              c[0] <= mx_c;
              c[1] <= '0;
              c[2] <= '0;
              a    <= mx_c;
            end
            MODE_FAKED: begin
              // alpha is 255 minus the ceil of the channel mean
              prod <= mul_p;
              job  <= JOB_FC_SUM;
            end
            MODE_INVERSE: begin
              for (int i = 0; i < NUM_CH; i++) c[i] <= '0;
              a <= CHAN_MAX - mx_c;
            end
          endcase
        end
        S_BL_MUL1: prod <= mul_p;
        S_BL_MUL2: begin
          tmp  <= prod[WIDE_W-1:0];
          prod <= mul_p;
        end
        S_BL_WR: begin
          c[ch] <= bl_sum[WIDE_W-1:CHAN_W];
          ch    <= (ch == CH_LAST) ? '0 : ch + 2'd1;
        end
        S_FC_MUL: begin
          prod <= mul_p;
          job  <= JOB_FC_CHAN;
        end
        S_OUT: begin
          if (out_free) begin
            o_red    <= c[0];
            o_green  <= c[1];
            o_blue   <= c[2];
            o_alpha  <= (mono_mode != MODE_NORMAL && translucent) ? CHAN_MAX : a;
            out_full <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // accumulators start clean for the next texel once the gamma reads are done
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK_WR && ch == CH_LAST) |=>
      (acc[0] == '0 && acc[1] == '0 && acc[2] == '0))
    else $error("accumulators not cleared after texel finish");

  // the divider needs the upper dividend half below the divisor
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_LD) |=> (den != '0 && div_rem < den))
    else $error("division quotient would overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} < (CNT_W + 1)'(MAX_STYLES)))
    else $error("style count reached its limit");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && samples.opcode == OP_GAMMA_LOAD) |=> (state == S_IDLE))
    else $error("gamma load left idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_full && !texels.ready) |=> (state == S_OUT))
    else $error("texel finished while output register busy");

endmodule
